### rtl/acir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acir_pkg;

    typedef logic [5:0] pos_t;
    typedef logic [4:0] idx_t;
    typedef logic [7:0] byte_t;

    // frame layout
    localparam pos_t HALF_LEN     = 6'd17;
    localparam pos_t SHORT_LEN    = 6'd14;
    localparam pos_t FRAME_LEN    = 6'd36;
    localparam pos_t REPEAT_START = 6'd18;
    localparam pos_t REPEAT_END   = 6'd35;
    localparam pos_t SHORT_END    = 6'd32;
    localparam pos_t MARKER_POS   = 6'd32;
    localparam pos_t POS_MAX      = 6'd37;

    localparam byte_t HEADER_BYTE = 8'h23;
    localparam byte_t MARKER_BYTE = 8'h24;

    // field masks
    localparam byte_t MODE_MASK    = 8'h38;
    localparam byte_t VANE_MASK    = 8'hF8;
    localparam byte_t WIDE_MASK    = 8'hF0;
    localparam byte_t AREA_MASK    = 8'hC0;
    localparam byte_t INSTALL_MASK = 8'h18;

    // repeat flag bits
    localparam int REP_ALL    = 0;
    localparam int REP_SHORT  = 1;
    localparam int REP_MARKER = 2;

    // setting codes
    localparam logic [1:0] POWER_OFF       = 2'd0;
    localparam logic [1:0] POWER_ON        = 2'd1;
    localparam logic [2:0] MODE_FAN        = 3'd0;
    localparam logic [2:0] MODE_AUTO       = 3'd1;
    localparam logic [2:0] MODE_HEAT       = 3'd2;
    localparam logic [2:0] MODE_MAINT_HEAT = 3'd3;
    localparam logic [2:0] MODE_COOL       = 3'd4;
    localparam logic [2:0] MODE_DRY        = 3'd5;
    localparam logic [2:0] FAN_TOP_SPEED   = 3'd4;
    localparam logic [3:0] VANE_AUTO1      = 4'd0;
    localparam logic [3:0] VANE_UP         = 4'd1;
    localparam logic [3:0] VANE_UP1        = 4'd2;
    localparam logic [3:0] VANE_UP2        = 4'd3;
    localparam logic [3:0] VANE_UP3        = 4'd4;
    localparam logic [3:0] VANE_DOWN       = 4'd5;
    localparam logic [3:0] VANE_SWING      = 4'd6;
    localparam logic [3:0] VANE_AUTO2      = 4'd7;
    localparam logic [3:0] VANE_AUTO3      = 4'd8;
    localparam logic [3:0] WIDE_SWING      = 4'd6;
    localparam logic [3:0] WIDE_SPLIT      = 4'd7;
    localparam logic [1:0] INSTALL_LEFT    = 2'd0;
    localparam logic [1:0] INSTALL_CENTER  = 2'd1;
    localparam logic [1:0] INSTALL_RIGHT   = 2'd2;

    // codes for unrecognised setting values
    localparam logic [1:0] POWER_UNKNOWN   = 2'd2;
    localparam logic [2:0] MODE_UNKNOWN    = 3'd6;
    localparam logic [2:0] FAN_UNKNOWN     = 3'd5;
    localparam logic [3:0] VANE_UNKNOWN    = 4'd9;
    localparam logic [3:0] WIDE_UNKNOWN    = 4'd8;
    localparam logic [1:0] INSTALL_UNKNOWN = 2'd3;

    localparam int OUT_BYTES = 5;

    typedef struct packed {
        logic [1:0] install_code;
        logic [1:0] area_mode_code;
        logic [3:0] wide_vane_code;
        logic [3:0] vane_code;
        logic [2:0] fan_code;
        logic [8:0] set_temperature;
        logic [2:0] feature_flags;
        logic [2:0] mode_code;
        logic [1:0] power_code;
        logic       checksum_ok;
        logic       frame_recognized;
    } frame_result_t;

endpackage

`default_nettype wire

### rtl/ac_ir_frame_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// decodes one 36-byte air-conditioner infrared frame delivered a byte per beat on the
// slave stream, with s_axis_tlast on the final byte, and emits one result beat per frame
// on the master stream; a byte is taken every cycle, it is held in the input register
// and then folded into the frame state, and the result of a frame is registered in the
// result register when its last beat is folded in; the update of position, checksum sum
// and repeat flags for every byte is what sets the rate of one byte per cycle,
// and input beats stall only when a finished result is still waiting on m_axis_tready
// while the next frame's last byte is ready to be folded in
module ac_ir_frame_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // frame_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] frame_recognized, [1] checksum_ok, [3:2] power_code, [6:4] mode_code,
    // [9:7] feature_flags, [18:10] set_temperature, [21:19] fan_code,
    // [25:22] vane_code, [29:26] wide_vane_code, [31:30] area_mode_code,
    // [33:32] install_code, [39:34] zero
    output logic [8*acir_pkg::OUT_BYTES-1:0] m_axis_tdata
);
    import acir_pkg::*;

    localparam int ResW = $bits(frame_result_t);

    // input register
    logic  in_valid_reg, in_valid_next;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // frame state
    pos_t       pos_reg, pos_next;
    byte_t      sum_reg, sum_next;
    logic       sum_ok_reg, sum_ok_next;
    logic [2:0] rep_reg, rep_next;
    byte_t      store_reg [HALF_LEN];

    // result register
    logic          out_valid_reg, out_valid_next;
    frame_result_t out_data_reg;
    frame_result_t res;

    logic  proc;
    logic  in_write;
    logic  in_repeat;
    pos_t  rd_pos;
    byte_t rd_byte;
    logic  frame_ok;
    byte_t b6, b7, b8, b9, b13, b14, b15;

    // the item in the input register moves on unless it would need a busy result register
    assign proc          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;

    assign in_write  = (pos_reg < HALF_LEN);
    assign in_repeat = (pos_reg >= REPEAT_START) && (pos_reg < REPEAT_END);
    assign rd_pos    = pos_reg - REPEAT_START;
    assign rd_byte   = store_reg[rd_pos[4:0]];

    // state update for the byte in the input register
    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        sum_ok_next = sum_ok_reg;
        rep_next    = rep_reg;
        if (in_write) begin
            sum_next = sum_reg + in_byte_reg;
        end else if (pos_reg == HALF_LEN) begin
            sum_ok_next = (sum_reg == in_byte_reg);
        end else if (in_repeat) begin
            if (in_byte_reg != rd_byte) begin
                rep_next[REP_ALL] = 1'b0;
                if (pos_reg < SHORT_END) begin
                    rep_next[REP_SHORT] = 1'b0;
                end
            end
            if ((pos_reg == MARKER_POS) && (in_byte_reg != MARKER_BYTE)) begin
                rep_next[REP_MARKER] = 1'b0;
            end
        end
        if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + 6'd1;
        end
    end

    // recognised only on the 36th byte; store is settled by then
    assign frame_ok = (pos_reg == FRAME_LEN - 6'd1) && (store_reg[0] == HEADER_BYTE) &&
                      (rep_next[REP_ALL] || (rep_next[REP_SHORT] && rep_next[REP_MARKER]));

    assign b6  = store_reg[6];
    assign b7  = store_reg[7];
    assign b8  = store_reg[8];
    assign b9  = store_reg[9];
    assign b13 = store_reg[13];
    assign b14 = store_reg[14];
    assign b15 = store_reg[15];

    // setting decode
    always_comb begin
        res = '0;
        if (frame_ok) begin
            res.frame_recognized = 1'b1;
            res.checksum_ok      = sum_ok_reg;

            unique case (store_reg[5])
                8'h00:   res.power_code = POWER_OFF;
                8'h20:   res.power_code = POWER_ON;
                default: res.power_code = POWER_UNKNOWN;
            endcase

            unique case (b6 & MODE_MASK)
                8'h38:   res.mode_code = MODE_FAN;
                8'h20:   res.mode_code = MODE_AUTO;
                8'h08:   res.mode_code = (b15 == 8'h20) ? MODE_MAINT_HEAT : MODE_HEAT;
                8'h18:   res.mode_code = MODE_COOL;
                8'h10:   res.mode_code = MODE_DRY;
                default: res.mode_code = MODE_UNKNOWN;
            endcase

            res.feature_flags   = {b15[6], b14[2], b6[6]};
            res.set_temperature = (b7 == 8'h00) ? 9'd10 : ({1'b0, b7} + 9'd16);
            res.fan_code        = (b9[2:0] <= FAN_TOP_SPEED) ? b9[2:0] : FAN_UNKNOWN;

            unique case (b9 & VANE_MASK)
                8'h40:   res.vane_code = VANE_AUTO1;
                8'h48:   res.vane_code = VANE_UP;
                8'h50:   res.vane_code = VANE_UP1;
                8'h58:   res.vane_code = VANE_UP2;
                8'h60:   res.vane_code = VANE_UP3;
                8'h68:   res.vane_code = VANE_DOWN;
                8'h78:   res.vane_code = VANE_SWING;
                8'h80:   res.vane_code = VANE_AUTO2;
                8'hB8:   res.vane_code = VANE_AUTO3;
                default: res.vane_code = VANE_UNKNOWN;
            endcase

            unique case (b8 & WIDE_MASK) inside
                8'h00, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50: res.wide_vane_code = b8[7:4];
                8'hC0:   res.wide_vane_code = WIDE_SWING;
                8'h80:   res.wide_vane_code = WIDE_SPLIT;
                default: res.wide_vane_code = WIDE_UNKNOWN;
            endcase

            res.area_mode_code = b13[7:6] & AREA_MASK[7:6];

            unique case (b14 & INSTALL_MASK)
                8'h08:   res.install_code = INSTALL_LEFT;
                8'h10:   res.install_code = INSTALL_CENTER;
                8'h18:   res.install_code = INSTALL_RIGHT;
                default: res.install_code = INSTALL_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            sum_ok_reg    <= 1'b0;
            rep_reg       <= 3'b111;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc) begin
                if (in_last_reg) begin
                    // frame end: back to the start state, store keeps its bytes
                    pos_reg    <= '0;
                    sum_reg    <= '0;
                    sum_ok_reg <= 1'b0;
                    rep_reg    <= 3'b111;
                end else begin
                    pos_reg    <= pos_next;
                    sum_reg    <= sum_next;
                    sum_ok_reg <= sum_ok_next;
                    rep_reg    <= rep_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (proc && in_last_reg) begin
            out_data_reg <= res;
        end
    end

    // first half of the frame
    always_ff @(posedge aclk) begin
        if (proc && in_write) begin
            store_reg[pos_reg[4:0]] <= in_byte_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8*OUT_BYTES-ResW){1'b0}}, out_data_reg};

    // an unrecognised frame carries nothing but zeros
    a_unrec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[8*OUT_BYTES-1:1] == '0))
        else $error("unrecognised frame result has non-zero fields");

    // position never runs past its saturation point
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("byte position beyond saturation");

    // folding in a last byte restarts the frame state
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_last_reg) |=> (pos_reg == '0 && sum_reg == '0 && rep_reg == 3'b111))
        else $error("frame state not restarted after last byte");

    // a recognised result always reports a temperature of at least ten
    a_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[18:10] >= 9'd10))
        else $error("recognised frame with temperature below ten");

endmodule

`default_nettype wire

### verif/ac_ir_frame_checker.sv
`timescale 1ns / 1ps

module ac_ir_frame_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,   // data_byte
    input  wire logic                             s_axis_tlast,   // frame_end
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [8*acir_pkg::OUT_BYTES-1:0] m_axis_tdata,   // frame_result_t, zero padded
    output int                                    mismatch_count,
    output int                                    results_outstanding
);
    import acir_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int RESULT_BITS = $bits(frame_result_t);

    localparam logic [8:0] TEMP_FLOOR      = 9'd10;
    localparam logic [8:0] TEMP_OFFSET     = 9'd16;
    localparam byte_t      SETTING_ON      = 8'h20;

    // vane and wide vane patterns, lowest byte is code 0
    localparam int VANE_KEY_COUNT = 9;
    localparam int WIDE_KEY_COUNT = 8;
    localparam logic [8*VANE_KEY_COUNT-1:0] VANE_KEYS =
        {8'hB8, 8'h80, 8'h78, 8'h68, 8'h60, 8'h58, 8'h50, 8'h48, 8'h40};
    localparam logic [8*WIDE_KEY_COUNT-1:0] WIDE_KEYS =
        {8'h80, 8'hC0, 8'h50, 8'h40, 8'h30, 8'h20, 8'h10, 8'h00};

    byte_t         half_store [HALF_LEN];
    pos_t          rx_pos;
    byte_t         byte_total;
    logic          sum_good;
    logic [2:0]    repeat_ok;
    frame_result_t expected_results [$];
    int            results_seen;

    task automatic restart_frame();
        rx_pos     = '0;
        byte_total = '0;
        sum_good   = 1'b0;
        repeat_ok  = '1;
    endtask

    function automatic frame_result_t decode_settings(input logic checksum_good);
        frame_result_t r;
        byte_t         b6, b8, b9, b14, b15;
        int            k;
        b6  = half_store[6];
        b8  = half_store[8];
        b9  = half_store[9];
        b14 = half_store[14];
        b15 = half_store[15];
        r = '0;
        r.frame_recognized = 1'b1;
        r.checksum_ok      = checksum_good;

        if (half_store[5] == 8'h00) begin
            r.power_code = POWER_OFF;
        end else if (half_store[5] == SETTING_ON) begin
            r.power_code = POWER_ON;
        end else begin
            r.power_code = POWER_UNKNOWN;
        end

        case (b6 & MODE_MASK)
            8'h38: r.mode_code = MODE_FAN;
            8'h20: r.mode_code = MODE_AUTO;
            8'h08: r.mode_code = (b15 == SETTING_ON) ? MODE_MAINT_HEAT : MODE_HEAT;
            8'h18: r.mode_code = MODE_COOL;
            8'h10: r.mode_code = MODE_DRY;
            default: r.mode_code = MODE_UNKNOWN;
        endcase

        r.feature_flags   = {b15[6], b14[2], b6[6]};
        r.set_temperature = (half_store[7] == 8'h00) ? TEMP_FLOOR
                                                     : {1'b0, half_store[7]} + TEMP_OFFSET;
        r.fan_code        = (b9[2:0] <= FAN_TOP_SPEED) ? b9[2:0] : FAN_UNKNOWN;

        r.vane_code = VANE_UNKNOWN;
        for (k = 0; k < VANE_KEY_COUNT; k++) begin
            if ((b9 & VANE_MASK) == VANE_KEYS[8*k +: 8]) r.vane_code = 4'(k);
        end
        r.wide_vane_code = WIDE_UNKNOWN;
        for (k = 0; k < WIDE_KEY_COUNT; k++) begin
            if ((b8 & WIDE_MASK) == WIDE_KEYS[8*k +: 8]) r.wide_vane_code = 4'(k);
        end

        r.area_mode_code = half_store[13][7:6];
        case (b14 & INSTALL_MASK)
            8'h08: r.install_code = INSTALL_LEFT;
            8'h10: r.install_code = INSTALL_CENTER;
            8'h18: r.install_code = INSTALL_RIGHT;
            default: r.install_code = INSTALL_UNKNOWN;
        endcase
        return r;
    endfunction

    task automatic fold_byte(input byte_t b, input logic last);
        pos_t          p;
        frame_result_t r;
        p = rx_pos;
        if (p < HALF_LEN) begin
            half_store[p] = b;
            byte_total    = byte_total + b;
        end else if (p == HALF_LEN) begin
            sum_good = (byte_total == b);
        end else if (p < REPEAT_END) begin
            if (b != half_store[p - REPEAT_START]) begin
                repeat_ok[REP_ALL] = 1'b0;
                if (p < SHORT_END) repeat_ok[REP_SHORT] = 1'b0;
            end
            if (p == MARKER_POS && b != MARKER_BYTE) repeat_ok[REP_MARKER] = 1'b0;
        end
        if (p < POS_MAX) rx_pos = p + 6'd1;

        if (last) begin
            r = '0;
            if (p + 6'd1 == FRAME_LEN && half_store[0] == HEADER_BYTE &&
                (repeat_ok[REP_ALL] || (repeat_ok[REP_SHORT] && repeat_ok[REP_MARKER])))
                r = decode_settings(sum_good);
            expected_results.push_back(r);
            restart_frame();
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
        end
    endtask

    task automatic check_result(input logic [8*OUT_BYTES-1:0] beat);
        frame_result_t want, got;
        got = beat[RESULT_BITS-1:0];
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result %0d: no result expected, got %h", results_seen, beat);
        end else begin
            want = expected_results.pop_front();
            compare_field("frame_recognized", want.frame_recognized, got.frame_recognized);
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
            compare_field("power_code", want.power_code, got.power_code);
            compare_field("mode_code", want.mode_code, got.mode_code);
            compare_field("feature_flags", want.feature_flags, got.feature_flags);
            compare_field("set_temperature", want.set_temperature, got.set_temperature);
            compare_field("fan_code", want.fan_code, got.fan_code);
            compare_field("vane_code", want.vane_code, got.vane_code);
            compare_field("wide_vane_code", want.wide_vane_code, got.wide_vane_code);
            compare_field("area_mode_code", want.area_mode_code, got.area_mode_code);
            compare_field("install_code", want.install_code, got.install_code);
            compare_field("padding", 0, beat[8*OUT_BYTES-1:RESULT_BITS]);
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_frame();
            expected_results.delete();
            results_seen = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) fold_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
        end
        results_outstanding = expected_results.size();
    end

endmodule

### verif/tb_ac_ir_frame_decoder_top.sv
`timescale 1ns / 1ps

module tb_ac_ir_frame_decoder_top;

    import acir_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 5;
    localparam int RANDOM_BYTES     = 1020;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PRESSURE_FRAMES  = 12;

    // how the first half of a frame is filled
    typedef enum {
        STYLE_RANDOM,
        STYLE_ZERO,
        STYLE_ONES,
        STYLE_MAINT_HEAT
    } frame_style_t;

    // what is broken in a frame, if anything
    typedef enum {
        FAULT_NONE,
        FAULT_CHECKSUM,
        FAULT_SHORT_REPEAT,
        FAULT_BAD_MARKER,
        FAULT_EARLY_MISMATCH,
        FAULT_HEADER,
        FAULT_TRUNCATED,
        FAULT_OVERLONG,
        FAULT_NOISE
    } frame_fault_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [8*OUT_BYTES-1:0] m_axis_tdata;

    int    mismatch_count;
    int    results_outstanding;
    int    cycle_count   = 0;
    int    bytes_sent    = 0;
    bit    src_quiet     = 1'b0;   // sender offers back to back beats while set
    bit    sink_hold_req = 1'b0;   // asks the result sink for its one long hold-off
    byte_t frame_bytes [$];

    // clock: 10 ns period
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    ac_ir_frame_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // watches both channels, predicts every frame result and compares
    ac_ir_frame_checker frame_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tlast        (s_axis_tlast),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[ac_ir_frame_decoder_top] ERROR");
            $finish;
        end
    end

    // idle stretch length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result sink: alternating ready and stall stretches, plus one long hold-off on request
    initial begin : result_sink
        int cycles_left;
        bit ready_phase;
        bit hold_taken;
        cycles_left = 0;
        ready_phase = 1'b0;
        hold_taken  = 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold_req && !hold_taken) begin
                // long hold-off counted here so the block fills up behind it
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                cycles_left = 0;
            end else begin
                if (cycles_left == 0) begin
                    ready_phase = !ready_phase;
                    cycles_left = ready_phase ? 0 : idle_len();
                    if (cycles_left == 0) begin
                        // ready stretch, sometimes a long one with no stalls at all
                        ready_phase = 1'b1;
                        cycles_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 8);
                    end
                end
                m_axis_tready <= ready_phase;
                cycles_left--;
                @(posedge aclk);
            end
        end
    end

    // one byte beat; valid stays high into the next beat unless a gap is taken
    task automatic send_beat(input byte_t b, input logic last);
        int gap;
        gap = src_quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= byte_t'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_bytes.size(); k++)
            send_beat(frame_bytes[k], k == frame_bytes.size() - 1);
        bytes_sent += frame_bytes.size();
    endtask

    // cut or pad with random bytes to the given length
    task automatic resize_frame(input int n);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        while (frame_bytes.size() < n) frame_bytes.push_back(byte_t'($urandom));
    endtask

    // builds a 36-byte frame with header, checksum and repeated half, then breaks it as asked
    task automatic build_frame(input frame_style_t style, input frame_fault_t fault);
        byte_t csum;
        byte_t v;
        int    k;
        frame_bytes.delete();
        csum = '0;
        for (k = 0; k < HALF_LEN; k++) begin
            case (style)
                STYLE_ZERO: frame_bytes.push_back(8'h00);
                STYLE_ONES: frame_bytes.push_back(8'hFF);
                default:    frame_bytes.push_back(byte_t'($urandom));
            endcase
        end
        frame_bytes[0] = HEADER_BYTE;

        if (style == STYLE_RANDOM) begin
            // bias the setting bytes towards the values with a meaning
            case ($urandom_range(0, 2))
                0: frame_bytes[5] = 8'h00;
                1: frame_bytes[5] = 8'h20;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: frame_bytes[7] = 8'h00;
                1: frame_bytes[7] = 8'hFF;
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 8))
                    0: v = 8'h40;
                    1: v = 8'h48;
                    2: v = 8'h50;
                    3: v = 8'h58;
                    4: v = 8'h60;
                    5: v = 8'h68;
                    6: v = 8'h78;
                    7: v = 8'h80;
                    default: v = 8'hB8;
                endcase
                frame_bytes[9] = v | (frame_bytes[9] & ~VANE_MASK);
            end
            if ($urandom_range(0, 2) == 0) frame_bytes[15] = 8'h20;
        end else if (style == STYLE_MAINT_HEAT) begin
            frame_bytes[6]  = (frame_bytes[6] & ~MODE_MASK) | 8'h08;
            frame_bytes[15] = 8'h20;
        end

        // the short repeat form only counts when the full repeat fails
        if ((fault == FAULT_SHORT_REPEAT || fault == FAULT_BAD_MARKER) &&
            frame_bytes[14] == MARKER_BYTE)
            frame_bytes[14] = MARKER_BYTE ^ 8'h01;

        for (k = 0; k < HALF_LEN; k++) csum += frame_bytes[k];
        frame_bytes.push_back(csum);
        for (k = 0; k < HALF_LEN; k++) frame_bytes.push_back(frame_bytes[k]);
        frame_bytes.push_back(byte_t'($urandom));

        case (fault)
            FAULT_CHECKSUM: begin
                frame_bytes[HALF_LEN] ^= byte_t'($urandom_range(1, 255));
            end
            FAULT_SHORT_REPEAT: begin
                // first 14 repeated bytes match, marker present, tail free
                frame_bytes[MARKER_POS]     = MARKER_BYTE;
                frame_bytes[MARKER_POS + 1] = byte_t'($urandom);
                frame_bytes[MARKER_POS + 2] = byte_t'($urandom);
            end
            FAULT_BAD_MARKER: begin
                do v = byte_t'($urandom);
                while (v == frame_bytes[14] || v == MARKER_BYTE);
                frame_bytes[MARKER_POS] = v;
            end
            FAULT_EARLY_MISMATCH: begin
                k = $urandom_range(REPEAT_START, SHORT_END - 1);
                frame_bytes[k] ^= byte_t'($urandom_range(1, 255));
                if ($urandom_range(0, 1) == 1) frame_bytes[MARKER_POS] = MARKER_BYTE;
            end
            FAULT_HEADER: begin
                frame_bytes[0] ^= byte_t'($urandom_range(1, 255));
                frame_bytes[REPEAT_START] = frame_bytes[0];
            end
            FAULT_TRUNCATED: resize_frame($urandom_range(1, FRAME_LEN - 1));
            FAULT_OVERLONG:  resize_frame($urandom_range(FRAME_LEN + 1, FRAME_LEN + 9));
            FAULT_NOISE: begin
                frame_bytes.delete();
                resize_frame($urandom_range(1, FRAME_LEN + 9));
            end
            default: ;
        endcase
    endtask

    task automatic run_frame(input frame_style_t style, input frame_fault_t fault);
        build_frame(style, fault);
        send_frame();
    endtask

    // sender stops and waits until every predicted result has been delivered
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_outstanding == 0);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int           random_start;
        int           pick;
        bit           pressure_done;
        frame_style_t style;
        frame_fault_t fault;
        pressure_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, maintenance heat, each repeat form and broken frames
        run_frame(STYLE_ZERO, FAULT_NONE);
        run_frame(STYLE_ONES, FAULT_NONE);
        run_frame(STYLE_MAINT_HEAT, FAULT_NONE);
        run_frame(STYLE_RANDOM, FAULT_SHORT_REPEAT);
        run_frame(STYLE_RANDOM, FAULT_BAD_MARKER);
        run_frame(STYLE_RANDOM, FAULT_EARLY_MISMATCH);
        run_frame(STYLE_RANDOM, FAULT_CHECKSUM);
        run_frame(STYLE_RANDOM, FAULT_HEADER);
        // single-byte frame, one byte short, one byte long, well past saturation
        build_frame(STYLE_RANDOM, FAULT_NONE);
        resize_frame(1);
        send_frame();
        build_frame(STYLE_RANDOM, FAULT_NONE);
        resize_frame(FRAME_LEN - 1);
        send_frame();
        build_frame(STYLE_RANDOM, FAULT_NONE);
        resize_frame(FRAME_LEN + 1);
        send_frame();
        build_frame(STYLE_ONES, FAULT_NONE);
        resize_frame(FRAME_LEN + 9);
        send_frame();
        run_frame(STYLE_RANDOM, FAULT_NOISE);

        // random: mostly well-formed frames with random settings, the rest broken or noise
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (!pressure_done && bytes_sent - random_start > RANDOM_BYTES / 3) begin
                // sink holds off while short frames keep coming, so the input stalls
                pressure_done = 1'b1;
                sink_hold_req <= 1'b1;
                src_quiet = 1'b1;
                repeat (PRESSURE_FRAMES) run_frame(STYLE_RANDOM, FAULT_TRUNCATED);
                src_quiet = 1'b0;
                drain_results();
            end

            pick = $urandom_range(0, 9);
            style = (pick == 0) ? STYLE_ZERO :
                    (pick == 1) ? STYLE_ONES :
                    (pick == 2) ? STYLE_MAINT_HEAT : STYLE_RANDOM;

            pick = $urandom_range(0, 99);
            if (pick < 47)      fault = FAULT_NONE;
            else if (pick < 57) fault = FAULT_CHECKSUM;
            else if (pick < 67) fault = FAULT_SHORT_REPEAT;
            else if (pick < 72) fault = FAULT_BAD_MARKER;
            else if (pick < 79) fault = FAULT_EARLY_MISMATCH;
            else if (pick < 84) fault = FAULT_HEADER;
            else if (pick < 91) fault = FAULT_TRUNCATED;
            else if (pick < 95) fault = FAULT_OVERLONG;
            else                fault = FAULT_NOISE;

            src_quiet = ($urandom_range(0, 5) == 0);
            run_frame(style, fault);
        end
        src_quiet = 1'b0;

        // let every result through, then a few more cycles for anything stray
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("[ac_ir_frame_decoder_top] OK");
        end else begin
            $display("[ac_ir_frame_decoder_top] ERROR");
        end
        $finish;
    end

endmodule
